// ----- design/rgb_to_hsv_pixel_defines.svh -----
// Assertion macros for the checker of the RGB to HSV pixel block.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Next-cycle implication, ignored while reset is high.
`define RHSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, ignored while reset is high.
`define RHSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RHSV_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rhsv_pkg.sv -----
// Package: widths, pipeline depth and channel-select codes for the RGB to HSV block.
package rhsv_pkg;

  localparam int PIX_W   = 8;
  localparam int FRAC_W  = 16;
  // 6 * chroma needs three more bits than a pixel channel
  localparam int DIV_W   = PIX_W + 3;
  localparam int NSTEP   = FRAC_W;
  localparam int NSTG    = NSTEP + 2;

  // Largest channel, with red winning ties over green and green over blue
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // Front stage: extremes and the raw hue difference
  typedef struct packed {
    logic [PIX_W-1:0]        v;
    logic [PIX_W-1:0]        m;
    logic signed [PIX_W+1:0] num;
    logic [1:0]              sel;
  } front_t;

  // Quotient stage: both fractional divisions advance one bit per stage
  typedef struct packed {
    logic [PIX_W-1:0]  v;
    logic [DIV_W-1:0]  d;
    logic [PIX_W-1:0]  srem;
    logic [DIV_W-1:0]  hrem;
    logic [FRAC_W-1:0] sq;
    logic [FRAC_W-1:0] hq;
    logic              sat_zero;
    logic              sat_full;
    logic              hue_zero;
  } stg_t;

endpackage

// ----- design/rgb_to_hsv_pixel.sv -----
// RGB to HSV pixel converter: 8-bit channels in, Q0.16 hue and saturation out.
// Pipeline: the two front stages (max/min, hue offset) and the 16-stage quotient
// pipeline that yields one bit of each fraction; one pixel per clock while the
// result side is not stalled.
// Bubbles close up under output stall; a full stage holds till its successor moves.
// Reset (rst, synchronous) clears the stage valid bits only; payload is not reset.
module rgb_to_hsv_pixel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic [rhsv_pkg::PIX_W-1:0]  red,
  input  logic [rhsv_pkg::PIX_W-1:0]  green,
  input  logic [rhsv_pkg::PIX_W-1:0]  blue,
  output logic                      hsv_valid,
  input  logic                      hsv_stall,
  output logic [rhsv_pkg::FRAC_W-1:0] hue,
  output logic [rhsv_pkg::FRAC_W-1:0] saturation,
  output logic [rhsv_pkg::PIX_W-1:0]  brightness
);
  import rhsv_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG-1:0] rdy;

  front_t front;
  front_t front_next;
  stg_t   dv [NSTEP+1];
  stg_t   dv0_next;

  // One restoring step for each of the two fractions
  function automatic stg_t div_step(input stg_t s);
    stg_t             n;
    logic [PIX_W:0]   st;
    logic [DIV_W:0]   ht;
    n  = s;
    st = {s.srem, 1'b0};
    ht = {s.hrem, 1'b0};
    if (st >= {1'b0, s.v}) begin
      n.srem = PIX_W'(st - {1'b0, s.v});
      n.sq   = {s.sq[FRAC_W-2:0], 1'b1};
    end else begin
      n.srem = st[PIX_W-1:0];
      n.sq   = {s.sq[FRAC_W-2:0], 1'b0};
    end
    if (ht >= {1'b0, s.d}) begin
      n.hrem = DIV_W'(ht - {1'b0, s.d});
      n.hq   = {s.hq[FRAC_W-2:0], 1'b1};
    end else begin
      n.hrem = ht[DIV_W-1:0];
      n.hq   = {s.hq[FRAC_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // Ready chain: a stage takes a beat when it is empty or its successor moves
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !hsv_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    vld_next = (rdy & {vld[NSTG-2:0], pix_valid}) | (~rdy & vld);
  end

  assign pix_stall = !rdy[0];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // Front stage: largest, smallest and the signed channel difference
  always_comb begin
    front_next = '0;
    if (red >= green && red >= blue) begin
      front_next.sel = SEL_RED;
    end else if (green >= blue) begin
      front_next.sel = SEL_GREEN;
    end else begin
      front_next.sel = SEL_BLUE;
    end
    front_next.m = red;
    if (green < front_next.m) front_next.m = green;
    if (blue < front_next.m) front_next.m = blue;
    unique case (front_next.sel)
      SEL_RED: begin
        front_next.v   = red;
        front_next.num = $signed({2'b00, green}) - $signed({2'b00, blue});
      end
      SEL_GREEN: begin
        front_next.v   = green;
        front_next.num = $signed({2'b00, blue}) - $signed({2'b00, red});
      end
      default: begin
        front_next.v   = blue;
        front_next.num = $signed({2'b00, red}) - $signed({2'b00, green});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      front <= front_next;
    end
  end

  // Second stage: chroma, sextant offset with wrap, divisor 6*C, special cases
  always_comb begin
    logic [PIX_W-1:0]        c;
    logic [PIX_W+1:0]        kc;
    logic [DIV_W-1:0]        d;
    logic signed [DIV_W+1:0] tw;
    c = front.v - front.m;
    d = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
    unique case (front.sel)
      SEL_RED:   kc = '0;
      SEL_GREEN: kc = {1'b0, c, 1'b0};
      default:   kc = {c, 2'b00};
    endcase
    tw = $signed({{2{front.num[PIX_W+1]}}, front.num}) + $signed({2'b00, kc});
    if (tw < 0) begin
      tw = tw + $signed({1'b0, d});
    end
    dv0_next.v        = front.v;
    dv0_next.d        = d;
    dv0_next.srem     = c;
    dv0_next.hrem     = tw[DIV_W-1:0];
    dv0_next.sq       = '0;
    dv0_next.hq       = '0;
    dv0_next.sat_zero = (front.v == '0);
    dv0_next.sat_full = (c == front.v);
    dv0_next.hue_zero = (c == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dv[0] <= dv0_next;
    end
  end

  // Quotient pipeline: one bit of hue and saturation per stage
  for (genvar j = 1; j <= NSTEP; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rdy[j+1]) begin
        dv[j] <= div_step(dv[j-1]);
      end
    end
  end

  // Drive result beat, applying black, gray and full-saturation cases
  assign hsv_valid  = vld[NSTG-1];
  assign brightness = dv[NSTEP].v;
  assign hue        = dv[NSTEP].hue_zero ? '0 : dv[NSTEP].hq;
  assign saturation = dv[NSTEP].sat_zero ? '0 :
                      (dv[NSTEP].sat_full ? '1 : dv[NSTEP].sq);

endmodule

// ----- design/rhsv_checker.sv -----
// Port-level checker for the RGB to HSV pixel block and its bind.
module rhsv_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_valid,
  input logic                      pix_stall,
  input logic [rhsv_pkg::PIX_W-1:0]  red,
  input logic [rhsv_pkg::PIX_W-1:0]  green,
  input logic [rhsv_pkg::PIX_W-1:0]  blue,
  input logic                      hsv_valid,
  input logic                      hsv_stall,
  input logic [rhsv_pkg::FRAC_W-1:0] hue,
  input logic [rhsv_pkg::FRAC_W-1:0] saturation,
  input logic [rhsv_pkg::PIX_W-1:0]  brightness
);
  import rhsv_pkg::*;
  `include "rgb_to_hsv_pixel_defines.svh"

  // Hold a stalled pixel beat
  `RHSV_ASSERT_NEXT(a_in_hold, pix_valid && pix_stall,
    pix_valid && $stable(red) && $stable(green) && $stable(blue),
    "stalled pixel beat changed")

  // Hold a stalled result beat
  `RHSV_ASSERT_NEXT(a_out_hold, hsv_valid && hsv_stall,
    hsv_valid && $stable(hue) && $stable(saturation) && $stable(brightness),
    "stalled result beat changed")

  // Black pixel gives zero saturation and zero hue
  `RHSV_ASSERT_NOW(a_black_sat, hsv_valid && brightness == '0,
    saturation == '0 && hue == '0, "black pixel with nonzero saturation or hue")

  // An empty output stage never stalls the input
  `RHSV_ASSERT_NOW(a_no_stall_empty, !hsv_valid, !pix_stall, "input stalled with empty output")

  // Drop all beats at reset
  `RHSV_ASSERT_ALWAYS_NEXT(a_reset_clear, rst, !hsv_valid && !pix_stall,
    "pipeline not empty after reset")

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_rhsv_checker (.*);

// ----- dv/tb_rgb_to_hsv_pixel.sv -----
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_pixel;
  import rhsv_pkg::*;

  localparam int N_DIRECTED  = 22;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 210;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [FRAC_W-1:0] hue;
    logic [FRAC_W-1:0] sat;
    logic [PIX_W-1:0]  bri;
  } hsv_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             typed;
    hsv_t             want;
  } pixel_row_t;

  typedef struct {
    int               idx;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    hsv_t             want;
  } hsv_expect_t;

  // Corner pixels; rows with typed set carry their result, the rest go to the predictor
  localparam pixel_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{0,   0,   0,   1, '{0,     0,     0}},    // black
    '{255, 255, 255, 1, '{0,     0,     255}},  // white
    '{255, 0,   0,   1, '{0,     65535, 255}},  // pure red, full saturation
    '{0,   255, 0,   1, '{21845, 65535, 255}},  // pure green, one third turn
    '{0,   0,   255, 1, '{43690, 65535, 255}},  // pure blue, two thirds turn
    '{128, 128, 128, 1, '{0,     0,     128}},  // mid gray
    '{1,   0,   0,   1, '{0,     65535, 1}},    // dimmest red
    '{255, 255, 0,   0, '{0, 0, 0}},            // red and green tie
    '{0,   255, 255, 0, '{0, 0, 0}},            // green and blue tie
    '{255, 0,   255, 0, '{0, 0, 0}},            // red and blue tie, hue wraps
    '{200, 10,  50,  0, '{0, 0, 0}},            // red largest, negative difference
    '{200, 150, 20,  0, '{0, 0, 0}},
    '{30,  220, 100, 0, '{0, 0, 0}},
    '{100, 220, 30,  0, '{0, 0, 0}},
    '{40,  90,  230, 0, '{0, 0, 0}},
    '{90,  40,  230, 0, '{0, 0, 0}},
    '{255, 254, 254, 0, '{0, 0, 0}},            // nearly gray, bright
    '{254, 255, 255, 0, '{0, 0, 0}},
    '{1,   2,   3,   0, '{0, 0, 0}},            // nearly black
    '{128, 127, 1,   0, '{0, 0, 0}},
    '{85,  170, 255, 0, '{0, 0, 0}},
    '{240, 15,  60,  0, '{0, 0, 0}}
  };

  localparam int unsigned IDLE_PCTS  [N_PHASES] = '{0, 88, 0, 33};
  localparam int unsigned STALL_PCTS [N_PHASES] = '{0, 0, 88, 33};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pix_valid = 1'b0;
  logic             pix_stall;
  logic [PIX_W-1:0] red = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] blue = '0;
  logic              hsv_valid;
  logic              hsv_stall = 1'b0;
  logic [FRAC_W-1:0] hue;
  logic [FRAC_W-1:0] saturation;
  logic [PIX_W-1:0]  brightness;

  hsv_expect_t hsv_expected_q [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          pixel_count = 0;
  int          result_count = 0;
  int          mismatch_count = 0;

  rgb_to_hsv_pixel u_dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always #5 clk = ~clk;

  // Compute the exact HSV of one pixel, fractions floored to Q0.16
  function automatic hsv_t hsv_of_pixel(input logic [PIX_W-1:0] r, g, b);
    logic [PIX_W-1:0] vmax, vmin, chroma;
    logic [1:0]       sel;
    int               turn;
    logic [31:0]      sat_q, hue_q;
    hsv_t             res;
    vmax = r;
    sel = SEL_RED;
    if (g > vmax) begin
      vmax = g;
      sel = SEL_GREEN;
    end
    if (b > vmax) begin
      vmax = b;
      sel = SEL_BLUE;
    end
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    chroma = vmax - vmin;
    if (vmax == 0) begin
      sat_q = 0;
    end else begin
      sat_q = (32'(chroma) << 16) / 32'(vmax);
      if (sat_q > 32'd65535) sat_q = 32'd65535;
    end
    if (chroma == 0) begin
      hue_q = 0;
    end else begin
      case (sel)
        SEL_RED:   turn = int'(g) - int'(b);
        SEL_GREEN: turn = int'(b) - int'(r) + 2 * int'(chroma);
        default:   turn = int'(r) - int'(g) + 4 * int'(chroma);
      endcase
      if (turn < 0) turn += 6 * int'(chroma);
      hue_q = (32'(turn) << 16) / (32'(chroma) * 32'd6);
      if (hue_q > 32'd65535) hue_q = 32'd65535;
    end
    res.hue = hue_q[FRAC_W-1:0];
    res.sat = sat_q[FRAC_W-1:0];
    res.bri = vmax;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one pixel beat, wait for its acceptance, and queue its expected result
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                            input logic typed, input hsv_t typed_want);
    hsv_expect_t e;
    while (32'($urandom_range(99)) < idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    e.idx = pixel_count;
    e.r = r;
    e.g = g;
    e.b = b;
    e.want = typed ? typed_want : hsv_of_pixel(r, g, b);
    hsv_expected_q.push_back(e);
    pixel_count++;
    @(negedge clk);
  endtask

  // Stall the result side at the phase's rate
  always @(negedge clk) begin
    hsv_stall <= (32'($urandom_range(99)) < stall_pct);
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    hsv_expect_t e;
    if (!rst && hsv_valid && !hsv_stall) begin
      if (hsv_expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (hue %0d sat %0d v %0d)",
                                  hue, saturation, brightness));
      end else begin
        e = hsv_expected_q.pop_front();
        result_count++;
        if (hue !== e.want.hue)
          report_mismatch($sformatf("pixel %0d (%0d,%0d,%0d) hue %0d, want %0d",
                                    e.idx, e.r, e.g, e.b, hue, e.want.hue));
        if (saturation !== e.want.sat)
          report_mismatch($sformatf("pixel %0d (%0d,%0d,%0d) saturation %0d, want %0d",
                                    e.idx, e.r, e.g, e.b, saturation, e.want.sat));
        if (brightness !== e.want.bri)
          report_mismatch($sformatf("pixel %0d (%0d,%0d,%0d) brightness %0d, want %0d",
                                    e.idx, e.r, e.g, e.b, brightness, e.want.bri));
      end
    end
  end

  // Stimulus: directed corners, then random pixels under four idle/stall mixes
  initial begin
    logic [PIX_W-1:0] r, g, b, top, other;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].g, DIRECTED_ROWS[i].b,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct = IDLE_PCTS[p];
      stall_pct = STALL_PCTS[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        case ($urandom_range(7))
          0: begin
            // gray
            g = r;
            b = r;
          end
          1: begin
            // two channels tie for the largest
            top = 8'($urandom_range(255));
            other = 8'($urandom_range(top));
            case ($urandom_range(2))
              0: begin r = top; g = top; b = other; end
              1: begin g = top; b = top; r = other; end
              default: begin r = top; b = top; g = other; end
            endcase
          end
          2: begin
            // one channel off, full saturation
            case ($urandom_range(2))
              0: r = '0;
              1: g = '0;
              default: b = '0;
            endcase
          end
          3: begin
            // nearly gray, small chroma
            top = 8'($urandom_range(250));
            r = top + 8'($urandom_range(5));
            g = top + 8'($urandom_range(5));
            b = top + 8'($urandom_range(5));
          end
          4: begin
            // dark pixel
            r = 8'($urandom_range(7));
            g = 8'($urandom_range(7));
            b = 8'($urandom_range(7));
          end
          default: ;
        endcase
        send_pixel(r, g, b, 1'b0, '0);
      end
    end
    pix_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (hsv_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d directed corners, the rest random) and checked %0d results",
             pixel_count, N_DIRECTED, result_count);
    $display("Idle/stall mixes run: none, sender 88%%, receiver 88%%, both 33%%; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("Timeout with %0d results still expected", hsv_expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
